// ----- design/rat_pkg.sv -----
// Package for the range address translation table.
// Holds the shared widths, opcode and status codes, and the sequencer states.
// No dependencies.
package rat_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned AW          = 64;
  localparam int unsigned STW         = 3;
  localparam int unsigned OPW         = 2;

  typedef enum logic [OPW-1:0] {
    OP_INSERT   = 2'd0,
    OP_DEL_ADDR = 2'd1,
    OP_DEL_TGT  = 2'd2,
    OP_XLATE    = 2'd3
  } op_t;

  typedef enum logic [STW-1:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_ZERO     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_DONE
  } state_t;

endpackage

// ----- design/rat_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the entry store of the range table. No dependencies.
module rat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [IW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- design/range_address_translation_table.sv -----
// Range address translation table: insert, delete by address or target, translate.
// A word is handled in order: the entry RAM is scanned through its registered read
// port, then the offset is formed, then the word is decided, the table written back
// and the result registered. A new word is accepted only in the idle state, so not
// before the last word has left its decide state; a stalled output holds a word in
// that state. Synchronous active-low reset clears all valid bits and the control state.
// Depends on rat_pkg and rat_ram.
module range_address_translation_table #(
  parameter int unsigned ENTRIES = rat_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rat_pkg::OPW-1:0]  in_opcode,
  input  logic [rat_pkg::AW-1:0]   in_address,
  input  logic [rat_pkg::AW-1:0]   in_region_size,
  input  logic [rat_pkg::AW-1:0]   in_target_base,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [rat_pkg::STW-1:0]  out_status,
  output logic [rat_pkg::AW-1:0]   out_translated
);

  import rat_pkg::*;

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned RW  = 3 * AW;
  localparam logic [CW-1:0] N_C = CW'(ENTRIES);

  state_t state_r, state_nxt;

  op_t           op_r, op_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] size_r, size_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pvld_r, pvld_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;

  logic          best_found_r, best_found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [AW-1:0] best_start_r, best_start_nxt;
  logic [AW-1:0] best_len_r, best_len_nxt;
  logic [AW-1:0] best_tgt_r, best_tgt_nxt;
  logic          match_found_r, match_found_nxt;
  logic [IW-1:0] match_idx_r, match_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [AW-1:0] off_r, off_nxt;

  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [AW-1:0] out_xlat_r, out_xlat_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic [AW-1:0] rd_start, rd_len, rd_tgt;
  logic          rd_valid;
  logic          start_le_addr, start_gt_best, start_lt_best;
  logic          accept, issue, scan_last, done_fire;

  rat_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_start = ram_rdata[3*AW-1:2*AW];
  assign rd_len   = ram_rdata[2*AW-1:AW];
  assign rd_tgt   = ram_rdata[AW-1:0];
  assign rd_valid = valid_r[pidx_r];

  // The scan compares each entry start with the address and with the best start so far.
  assign start_le_addr = (rd_start <= addr_r);
  assign start_gt_best = (rd_start > best_start_r);
  assign start_lt_best = (rd_start < best_start_r);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign issue     = (state_r == S_SCAN) && (cnt_r < N_C);
  assign scan_last = (state_r == S_SCAN) && (cnt_r == N_C) && pvld_r;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_translated = out_xlat_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    logic          hit;
    logic [IW-1:0] slot;
    op_nxt          = op_r;
    addr_nxt        = addr_r;
    size_nxt        = size_r;
    tgt_nxt         = tgt_r;
    cnt_nxt         = cnt_r;
    pvld_nxt        = issue;
    pidx_nxt        = cnt_r[IW-1:0];
    best_found_nxt  = best_found_r;
    best_idx_nxt    = best_idx_r;
    best_start_nxt  = best_start_r;
    best_len_nxt    = best_len_r;
    best_tgt_nxt    = best_tgt_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    off_nxt         = off_r;
    valid_nxt       = valid_r;
    out_status_nxt  = out_status_r;
    out_xlat_nxt    = out_xlat_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    ram_we          = 1'b0;
    ram_waddr       = match_idx_r;
    ram_wdata       = {addr_r, size_r, tgt_r};
    hit             = best_found_r && (off_r < best_len_r);
    slot            = match_found_r ? match_idx_r : free_idx_r;

    if (accept) begin
      op_nxt          = op_t'(in_opcode);
      addr_nxt        = in_address;
      size_nxt        = in_region_size;
      tgt_nxt         = in_target_base;
      cnt_nxt         = '0;
      best_found_nxt  = 1'b0;
      match_found_nxt = 1'b0;
      free_found_nxt  = 1'b0;
    end

    if (issue) begin
      cnt_nxt = cnt_r + CW'(1);
    end

    if ((state_r == S_SCAN) && pvld_r) begin
      case (op_r)
        OP_INSERT: begin
          if (rd_valid && (rd_start == addr_r) && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = pidx_r;
          end
          if (!rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pidx_r;
          end
        end
        OP_DEL_TGT: begin
          if (rd_valid && (rd_tgt == tgt_r) && (!best_found_r || start_lt_best)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = pidx_r;
            best_start_nxt = rd_start;
          end
        end
        default: begin
          if (rd_valid && start_le_addr && (!best_found_r || start_gt_best)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = pidx_r;
            best_start_nxt = rd_start;
            best_len_nxt   = rd_len;
            best_tgt_nxt   = rd_tgt;
          end
        end
      endcase
    end

    if (state_r == S_CALC) begin
      off_nxt = addr_r - best_start_r;
    end

    if (done_fire) begin
      out_valid_nxt = 1'b1;
      out_xlat_nxt  = '0;
      case (op_r)
        OP_INSERT: begin
          ram_waddr = slot;
          if (addr_r == '0) begin
            out_status_nxt = ST_ZERO;
          end else if (match_found_r || free_found_r) begin
            out_status_nxt  = ST_OK;
            ram_we          = 1'b1;
            valid_nxt[slot] = 1'b1;
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
        OP_DEL_ADDR: begin
          if (hit) begin
            out_status_nxt        = ST_OK;
            valid_nxt[best_idx_r] = 1'b0;
          end else begin
            out_status_nxt = ST_NOTFOUND;
          end
        end
        OP_DEL_TGT: begin
          if (best_found_r) begin
            out_status_nxt        = ST_OK;
            valid_nxt[best_idx_r] = 1'b0;
          end else begin
            out_status_nxt = ST_NOTFOUND;
          end
        end
        default: begin
          if (hit) begin
            out_status_nxt = ST_OK;
            out_xlat_nxt   = best_tgt_r + off_r;
          end else begin
            out_status_nxt = ST_MISS;
            out_xlat_nxt   = addr_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pvld_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pvld_r      <= pvld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    addr_r        <= addr_nxt;
    size_r        <= size_nxt;
    tgt_r         <= tgt_nxt;
    pidx_r        <= pidx_nxt;
    best_found_r  <= best_found_nxt;
    best_idx_r    <= best_idx_nxt;
    best_start_r  <= best_start_nxt;
    best_len_r    <= best_len_nxt;
    best_tgt_r    <= best_tgt_nxt;
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    off_r         <= off_nxt;
    out_status_r  <= out_status_nxt;
    out_xlat_r    <= out_xlat_nxt;
  end

endmodule
